// ----- rtl/bfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, register indexes and helpers for the box frustum culler.
// ----------------------------------------------------------------------------
package bfc_pkg;

    typedef logic signed [31:0] coord_t;   // signed Q16.16
    typedef logic signed [47:0] prod_t;    // product floored to Q32.16, 48 bits
    typedef logic signed [49:0] sum_t;     // exact sum of three products and t

    // Advance strobes of the four pipeline stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } stage_en_t;

    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgAddrW-1:0] REG_ROW_X_AB  = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_ROW_X_CT  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_ROW_Y_AB  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_ROW_Y_CT  = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_ROW_Z_AB  = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_ROW_Z_CT  = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_NEAR      = 3'd6;
    localparam logic [CfgAddrW-1:0] REG_FAR       = 3'd7;

    localparam coord_t ONE_Q16   = 32'sh0001_0000;
    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = -32'sh7FFF_FFFF - 32'sh1;

    // Clamp a wide sum to the signed 32-bit range
    function automatic coord_t sat32(input sum_t v);
        coord_t r;
        if (v[49] && !(&v[48:31]))
        begin
            r = COORD_MIN;
        end
        else if (!v[49] && (|v[48:31]))
        begin
            r = COORD_MAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/bfc_mul.sv -----
// ----------------------------------------------------------------------------
// bfc_mul
// Stage 1: multiply each matrix coefficient by the low and high coordinate
// of its axis and floor the products to Q32.16.
// ----------------------------------------------------------------------------
module bfc_mul
(
    input  logic                clk,
    input  bfc_pkg::stage_en_t  en,
    input  bfc_pkg::coord_t     coef [3][3],   // [row][axis]
    input  bfc_pkg::coord_t     lo [3],        // box minimum per axis
    input  bfc_pkg::coord_t     hi [3],        // box maximum per axis
    output bfc_pkg::prod_t      prod [3][3][2] // [row][axis][0=lo,1=hi]
);

    logic signed [63:0] full [3][3][2];
    bfc_pkg::prod_t     prod_reg [3][3][2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                full[r][c][0] = coef[r][c] * lo[c];
                full[r][c][1] = coef[r][c] * hi[c];
            end
        end
    end

    // Arithmetic shift right by 16 is floor toward minus infinity
    always_ff @(posedge clk)
    begin
        if (en.en1)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    for (int h = 0; h < 2; h++)
                    begin
                        prod_reg[r][c][h] <= full[r][c][h][63:16];
                    end
                end
            end
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/bfc_sum.sv -----
// ----------------------------------------------------------------------------
// bfc_sum
// Stage 2: combine products into the eight transformed corners, add the
// translation and saturate each coordinate.
// ----------------------------------------------------------------------------
module bfc_sum
(
    input  logic                clk,
    input  bfc_pkg::stage_en_t  en,
    input  bfc_pkg::prod_t      prod [3][3][2],
    input  bfc_pkg::coord_t     trans [3],
    output bfc_pkg::coord_t     corner [8][3]   // [corner][x,y,z]
);

    bfc_pkg::sum_t   sum [8][3];
    bfc_pkg::coord_t corner_reg [8][3];

    // Corner k takes the high x when bit 0 is set, high y on bit 1, high z on bit 2
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum[k][r] = bfc_pkg::sum_t'(prod[r][0][k[0]])
                          + bfc_pkg::sum_t'(prod[r][1][k[1]])
                          + bfc_pkg::sum_t'(prod[r][2][k[2]])
                          + bfc_pkg::sum_t'(trans[r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en2)
        begin
            for (int k = 0; k < 8; k++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    corner_reg[k][r] <= bfc_pkg::sat32(sum[k][r]);
                end
            end
        end
    end

    assign corner = corner_reg;

endmodule

// ----- rtl/bfc_test.sv -----
// ----------------------------------------------------------------------------
// bfc_test
// Stages 3 and 4: plane tests per corner and pairwise depth minimum, then
// reduce over all corners into the visible flag and the nearest depth.
// ----------------------------------------------------------------------------
module bfc_test
(
    input  logic                clk,
    input  bfc_pkg::stage_en_t  en,
    input  bfc_pkg::coord_t     corner [8][3],
    input  bfc_pkg::coord_t     near_plane,
    input  bfc_pkg::coord_t     far_plane,
    output logic                visible,
    output bfc_pkg::coord_t     nearest_depth
);

    // Flag bits: 0 near, 1 far, 2 left, 3 right, 4 bottom, 5 top
    logic [5:0]         out_flag [8];
    logic [5:0]         flag_reg [8];
    logic signed [32:0] neg_x [8];
    logic signed [32:0] neg_y [8];
    bfc_pkg::coord_t    pair_min [4];
    bfc_pkg::coord_t    pair_min_reg [4];
    bfc_pkg::coord_t    quad_min [2];
    bfc_pkg::coord_t    all_min;
    logic [5:0]         all_out;
    logic               visible_reg;
    bfc_pkg::coord_t    depth_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            // Negate at 33 bits so the most negative value does not wrap
            neg_x[k] = -(33'(corner[k][0]));
            neg_y[k] = -(33'(corner[k][1]));
            out_flag[k][0] = corner[k][2] <= near_plane;
            out_flag[k][1] = corner[k][2] >= far_plane;
            out_flag[k][2] = neg_x[k] >= 33'(corner[k][2]);
            out_flag[k][3] = corner[k][0] >= corner[k][2];
            out_flag[k][4] = neg_y[k] >= 33'(corner[k][2]);
            out_flag[k][5] = corner[k][1] >= corner[k][2];
        end
        for (int i = 0; i < 4; i++)
        begin
            pair_min[i] = (corner[2*i+1][2] < corner[2*i][2]) ? corner[2*i+1][2]
                                                             : corner[2*i][2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en3)
        begin
            flag_reg     <= out_flag;
            pair_min_reg <= pair_min;
        end
    end

    always_comb
    begin
        all_out = '1;
        for (int k = 0; k < 8; k++)
        begin
            all_out = all_out & flag_reg[k];
        end
        quad_min[0] = (pair_min_reg[1] < pair_min_reg[0]) ? pair_min_reg[1] : pair_min_reg[0];
        quad_min[1] = (pair_min_reg[3] < pair_min_reg[2]) ? pair_min_reg[3] : pair_min_reg[2];
        all_min     = (quad_min[1] < quad_min[0]) ? quad_min[1] : quad_min[0];
    end

    // Cull when every corner is outside one and the same plane
    always_ff @(posedge clk)
    begin
        if (en.en4)
        begin
            visible_reg <= ~(|all_out);
            depth_reg   <= all_min;
        end
    end

    assign visible       = visible_reg;
    assign nearest_depth = depth_reg;

endmodule

// ----- rtl/box_frustum_cull_top.sv -----
// ----------------------------------------------------------------------------
// box_frustum_cull_top
// Axis-aligned box against a view frustum, one box per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Each box enters on the input stream and leaves as one result: stage 1
// forms the eighteen coefficient-by-coordinate products, stage 2 sums them
// into the eight saturated corners, stage 3 runs the six plane tests per
// corner and a first depth minimum, and stage 4, which is also the output
// register, reduces over the corners. A new box is taken every cycle while
// the output is not stalled; each stage-1 multiplier gives one product per
// cycle. Empty stages keep taking input while a result waits at the output,
// and a stall holds each full stage with no empty stage after it. The matrix
// and planes are read live, so write them only with the pipeline empty.
// ----------------------------------------------------------------------------
module box_frustum_cull_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bfc_pkg::CfgAddrW-1:0]      cfg_addr,
    input  logic [bfc_pkg::CfgDataW-1:0]      cfg_data,
    // box input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [191:0]                      s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // visible [0], nearest_depth [32:1], zero [39:33]
    output logic [39:0]                       m_tdata
);

    bfc_pkg::coord_t    coef_reg [3][3];
    bfc_pkg::coord_t    trans_reg [3];
    bfc_pkg::coord_t    near_reg;
    bfc_pkg::coord_t    far_reg;

    bfc_pkg::coord_t    lo [3];
    bfc_pkg::coord_t    hi [3];
    bfc_pkg::prod_t     prod [3][3][2];
    bfc_pkg::coord_t    corner [8][3];
    logic               visible;
    bfc_pkg::coord_t    nearest_depth;

    bfc_pkg::stage_en_t en;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    coef_reg[r][c] <= (r == c) ? bfc_pkg::ONE_Q16 : '0;
                end
                trans_reg[r] <= '0;
            end
            near_reg <= '0;
            far_reg  <= bfc_pkg::COORD_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bfc_pkg::REG_ROW_X_AB:
                begin
                    coef_reg[0][0] <= cfg_data[63:32];
                    coef_reg[0][1] <= cfg_data[31:0];
                end
                bfc_pkg::REG_ROW_X_CT:
                begin
                    coef_reg[0][2] <= cfg_data[63:32];
                    trans_reg[0]   <= cfg_data[31:0];
                end
                bfc_pkg::REG_ROW_Y_AB:
                begin
                    coef_reg[1][0] <= cfg_data[63:32];
                    coef_reg[1][1] <= cfg_data[31:0];
                end
                bfc_pkg::REG_ROW_Y_CT:
                begin
                    coef_reg[1][2] <= cfg_data[63:32];
                    trans_reg[1]   <= cfg_data[31:0];
                end
                bfc_pkg::REG_ROW_Z_AB:
                begin
                    coef_reg[2][0] <= cfg_data[63:32];
                    coef_reg[2][1] <= cfg_data[31:0];
                end
                bfc_pkg::REG_ROW_Z_CT:
                begin
                    coef_reg[2][2] <= cfg_data[63:32];
                    trans_reg[2]   <= cfg_data[31:0];
                end
                bfc_pkg::REG_NEAR:
                begin
                    near_reg <= cfg_data[31:0];
                end
                bfc_pkg::REG_FAR:
                begin
                    far_reg <= cfg_data[31:0];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or its
    // successor advances
    // ------------------------------------------------------------------
    always_comb
    begin
        en.en4 = !v4_reg || m_tready;
        en.en3 = !v3_reg || en.en4;
        en.en2 = !v2_reg || en.en3;
        en.en1 = !v1_reg || en.en2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign s_tready = en.en1;
    assign m_tvalid = v4_reg;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = s_tdata[32*i +: 32];
            hi[i] = s_tdata[32*(i+3) +: 32];
        end
    end

    bfc_mul u_mul
    (
        .clk   (clk),
        .en    (en),
        .coef  (coef_reg),
        .lo    (lo),
        .hi    (hi),
        .prod  (prod)
    );

    bfc_sum u_sum
    (
        .clk    (clk),
        .en     (en),
        .prod   (prod),
        .trans  (trans_reg),
        .corner (corner)
    );

    bfc_test u_test
    (
        .clk           (clk),
        .en            (en),
        .corner        (corner),
        .near_plane    (near_reg),
        .far_plane     (far_reg),
        .visible       (visible),
        .nearest_depth (nearest_depth)
    );

    assign m_tdata = {7'd0, nearest_depth, visible};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer not held in stage 1");

    a_stage3_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !m_tready) |=> v3_reg)
        else $error("stage 3 item dropped during output stall");

    a_visible_before_far: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && visible) |-> (nearest_depth < far_reg))
        else $error("visible box with nearest depth at or beyond far plane");

endmodule
